### hdl/vvs_pkg.sv
`timescale 1ns / 1ps
package vvs_pkg;

  localparam int unsigned VvsDepth = 65536;

  localparam int unsigned IdxW    = 49;
  localparam int unsigned CfgAddrW = 5;
  localparam int unsigned CfgDataW = 32;

  localparam logic [15:0] VoxPerUmRst  = 16'h0100;
  localparam logic [3:0]  EmptyStateRst = 4'h0;
  localparam logic [7:0]  DistMax       = 8'hFF;

  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_COMP  = 2'd2,
    FUNC_RSVD  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    REG_DIM_X   = 3'd0,
    REG_DIM_Y   = 3'd1,
    REG_DIM_Z   = 3'd2,
    REG_VOX_UM  = 3'd3,
    REG_BLACK   = 3'd4,
    REG_OOB     = 3'd5,
    REG_EMPTY   = 3'd6,
    REG_NONE    = 3'd7
  } reg_e;

  typedef struct packed {
    logic [15:0] dim_x;
    logic [15:0] dim_y;
    logic [15:0] dim_z;
    logic [15:0] vox_per_um;
    logic [3:0]  black_state;
    logic [3:0]  oob_state;
    logic [3:0]  empty_state;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  state;
    logic [7:0]  edge_vox;
    logic [63:0] parent;
  } entry_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic mul1;
    logic mul2;
    logic sum;
    logic read;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
  } stat_t;

endpackage

### hdl/vvs_cfg.sv
`timescale 1ns / 1ps
module vvs_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vvs_pkg::CfgAddrW-1:0]  paddr,
  input  logic [vvs_pkg::CfgDataW-1:0]  pwdata,
  output logic [vvs_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready,
  output vvs_pkg::cfg_t                 cfg_o
);
  import vvs_pkg::*;

  cfg_t cfg_q;
  reg_e sel;
  logic wr_en;

  assign sel    = reg_e'(paddr[CfgAddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dim_x       <= '0;
      cfg_q.dim_y       <= '0;
      cfg_q.dim_z       <= '0;
      cfg_q.vox_per_um  <= VoxPerUmRst;
      cfg_q.black_state <= '0;
      cfg_q.oob_state   <= '0;
      cfg_q.empty_state <= EmptyStateRst;
    end else if (wr_en) begin
      unique case (sel)
        REG_DIM_X:  cfg_q.dim_x       <= pwdata[15:0];
        REG_DIM_Y:  cfg_q.dim_y       <= pwdata[15:0];
        REG_DIM_Z:  cfg_q.dim_z       <= pwdata[15:0];
        REG_VOX_UM: cfg_q.vox_per_um  <= pwdata[15:0];
        REG_BLACK:  cfg_q.black_state <= pwdata[3:0];
        REG_OOB:    cfg_q.oob_state   <= pwdata[3:0];
        REG_EMPTY:  cfg_q.empty_state <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (sel)
      REG_DIM_X:  prdata = {16'h0, cfg_q.dim_x};
      REG_DIM_Y:  prdata = {16'h0, cfg_q.dim_y};
      REG_DIM_Z:  prdata = {16'h0, cfg_q.dim_z};
      REG_VOX_UM: prdata = {16'h0, cfg_q.vox_per_um};
      REG_BLACK:  prdata = {28'h0, cfg_q.black_state};
      REG_OOB:    prdata = {28'h0, cfg_q.oob_state};
      REG_EMPTY:  prdata = {28'h0, cfg_q.empty_state};
      default:    prdata = '0;
    endcase
  end

endmodule

### hdl/vvs_ctrl.sv
`timescale 1ns / 1ps
module vvs_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  vvs_pkg::stat_t stat_i,
  output vvs_pkg::cmd_t  cmd_o
);
  import vvs_pkg::*;

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_MUL1   = 7'b0000100,
    ST_MUL2   = 7'b0001000,
    ST_SUM    = 7'b0010000,
    ST_READ   = 7'b0100000,
    ST_UPDATE = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:  if (stat_i.clear_last) state_d = ST_IDLE;
      ST_IDLE:   if (start) state_d = ST_MUL1;
      ST_MUL1:   state_d = ST_MUL2;
      ST_MUL2:   state_d = ST_SUM;
      ST_SUM:    state_d = ST_READ;
      ST_READ:   state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_IDLE;
      default:   state_d = ST_CLEAR;
    endcase
  end

  assign busy = (state_q != ST_IDLE);

  assign cmd_o.clear  = (state_q == ST_CLEAR);
  assign cmd_o.load   = (state_q == ST_IDLE) && start;
  assign cmd_o.mul1   = (state_q == ST_MUL1);
  assign cmd_o.mul2   = (state_q == ST_MUL2);
  assign cmd_o.sum    = (state_q == ST_SUM);
  assign cmd_o.read   = (state_q == ST_READ);
  assign cmd_o.update = (state_q == ST_UPDATE);

endmodule

### hdl/vvs_dp.sv
`timescale 1ns / 1ps
module vvs_dp #(
  parameter int unsigned DEPTH = vvs_pkg::VvsDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  vvs_pkg::cmd_t        cmd_i,
  output vvs_pkg::stat_t       stat_o,
  input  vvs_pkg::cfg_t        cfg_i,
  input  logic [1:0]           func_i,
  input  logic signed [15:0]   x_i,
  input  logic signed [15:0]   y_i,
  input  logic signed [15:0]   z_i,
  input  logic [3:0]           voxel_state_i,
  input  logic [7:0]           edge_voxels_i,
  input  logic [15:0]          edge_distance_um_i,
  input  logic [63:0]          parent_id_i,
  output logic                 done_o,
  output logic [3:0]           out_state_o,
  output logic [7:0]           out_edge_voxels_o,
  output logic [63:0]          out_parent_id_o,
  output logic                 oob_flag_o
);
  import vvs_pkg::*;

  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [IdxW-1:0] DepthIdx = IdxW'(DEPTH);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(DEPTH - 1);

  entry_t mem [DEPTH];

  func_e        func_q;
  logic [15:0]  x_q, y_q, z_q;
  logic [3:0]   vstate_q;
  logic [7:0]   evox_q;
  logic [15:0]  edist_q;
  logic [63:0]  parent_q;

  logic [31:0]  yz_q, ydz_q, vprod;
  logic [7:0]   vox_q;
  logic         coord_ok_q, coord_ok_d;
  logic [47:0]  xyz_q;
  logic [32:0]  ysum_q;
  logic [IdxW-1:0] idx_sum;
  logic         ok_q;
  logic [AddrW-1:0] addr_q;
  logic [AddrW-1:0] clr_q;
  entry_t       rd_q;
  entry_t       upd;
  logic         wr_en;
  logic         mem_we;
  logic [AddrW-1:0] mem_waddr;
  entry_t       mem_wdata;

  logic         done_q;
  entry_t       out_q;
  logic         oor_q;

  assign stat_o.clear_last = (clr_q == LastAddr);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q   <= func_e'(func_i);
      x_q      <= x_i;
      y_q      <= y_i;
      z_q      <= z_i;
      vstate_q <= voxel_state_i;
      evox_q   <= edge_voxels_i;
      edist_q  <= edge_distance_um_i;
      parent_q <= parent_id_i;
    end
  end

  assign coord_ok_d = !x_q[15] && !y_q[15] && !z_q[15] &&
                      (x_q < cfg_i.dim_x) && (y_q < cfg_i.dim_y) && (z_q < cfg_i.dim_z);
  assign vprod = {16'h0, edist_q} * {16'h0, cfg_i.vox_per_um};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul1) begin
      yz_q       <= {16'h0, cfg_i.dim_y} * {16'h0, cfg_i.dim_z};
      ydz_q      <= {16'h0, y_q} * {16'h0, cfg_i.dim_z};
      vox_q      <= (|vprod[31:24]) ? DistMax : vprod[23:16];
      coord_ok_q <= coord_ok_d;
    end
    if (cmd_i.mul2) begin
      xyz_q  <= {32'h0, x_q} * {16'h0, yz_q};
      ysum_q <= {1'b0, ydz_q} + {17'h0, z_q};
    end
    if (cmd_i.sum) begin
      ok_q   <= coord_ok_q && (idx_sum < DepthIdx);
      addr_q <= idx_sum[AddrW-1:0];
    end
  end

  assign idx_sum = {1'b0, xyz_q} + {16'h0, ysum_q};

  always_comb begin
    upd = rd_q;
    case (func_q)
      FUNC_WRITE: begin
        upd.state    = vstate_q;
        upd.edge_vox = evox_q;
        upd.parent   = parent_q;
      end
      FUNC_COMP: begin
        if (rd_q.edge_vox < vox_q) upd.edge_vox = vox_q;
        if (rd_q.state < cfg_i.black_state) upd.state = vstate_q;
        upd.parent = parent_q;
      end
      default: upd = rd_q;
    endcase
  end

  assign wr_en     = cmd_i.update && ok_q && ((func_q == FUNC_WRITE) || (func_q == FUNC_COMP));
  assign mem_we    = cmd_i.clear || wr_en;
  assign mem_waddr = cmd_i.clear ? clr_q : addr_q;
  assign mem_wdata = cmd_i.clear ? entry_t'({EmptyStateRst, 8'h00, 64'h0}) : upd;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.read) begin
      rd_q <= mem[addr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_q <= clr_q + AddrW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.update;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      if (ok_q) begin
        out_q <= upd;
        oor_q <= 1'b0;
      end else begin
        out_q <= entry_t'({cfg_i.oob_state, 8'h00, 64'h0});
        oor_q <= 1'b1;
      end
    end
  end

  assign done_o            = done_q;
  assign out_state_o       = out_q.state;
  assign out_edge_voxels_o = out_q.edge_vox;
  assign out_parent_id_o   = out_q.parent;
  assign oob_flag_o        = oor_q;

endmodule

### hdl/voxel_volume_store.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake                    Payload
// request  in         start high, busy low         func_i x_i y_i z_i voxel_state_i
//                                                  edge_voxels_i edge_distance_um_i
//                                                  parent_id_i
// result   out        done_o high for one cycle    out_state_o out_edge_voxels_o
//                                                  out_parent_id_o oob_flag_o
// config   in         APB write, pready always 1   pwdata to register paddr[4:2]
//
// Each request passes through five steps: the two index multiplier steps, the
// bounds compare, the single-port entry memory read and the update write-back;
// the result shows on done_o in the cycle in which the next request can be accepted.
// After reset the memory is swept to its reset value one entry a cycle, with
// busy high; configuration writes are taken during the sweep.
// The receiver cannot stall; results are never held.
module voxel_volume_store #(
  parameter int unsigned DEPTH = vvs_pkg::VvsDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    func_i,
  input  logic signed [15:0]            x_i,
  input  logic signed [15:0]            y_i,
  input  logic signed [15:0]            z_i,
  input  logic [3:0]                    voxel_state_i,
  input  logic [7:0]                    edge_voxels_i,
  input  logic [15:0]                   edge_distance_um_i,
  input  logic [63:0]                   parent_id_i,
  output logic                          done_o,
  output logic [3:0]                    out_state_o,
  output logic [7:0]                    out_edge_voxels_o,
  output logic [63:0]                   out_parent_id_o,
  output logic                          oob_flag_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vvs_pkg::CfgAddrW-1:0]  paddr,
  input  logic [vvs_pkg::CfgDataW-1:0]  pwdata,
  output logic [vvs_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready
);
  import vvs_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  vvs_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  vvs_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  vvs_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .cfg_i              (cfg),
    .func_i             (func_i),
    .x_i                (x_i),
    .y_i                (y_i),
    .z_i                (z_i),
    .voxel_state_i      (voxel_state_i),
    .edge_voxels_i      (edge_voxels_i),
    .edge_distance_um_i (edge_distance_um_i),
    .parent_id_i        (parent_id_i),
    .done_o             (done_o),
    .out_state_o        (out_state_o),
    .out_edge_voxels_o  (out_edge_voxels_o),
    .out_parent_id_o    (out_parent_id_o),
    .oob_flag_o         (oob_flag_o)
  );

endmodule
